// ===== rtl/gdrpm_pkg.sv =====
// Shared types and constants of the greedy delta-R pair matcher.
package gdrpm_pkg;

  typedef enum logic [1:0] {
    REQ_RECO  = 2'd0,
    REQ_TRUTH = 2'd1,
    REQ_EOE   = 2'd2,
    REQ_RSV   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_RECO_PT  = 2'd0,
    CFG_TRUTH_PT = 2'd1,
    CFG_ETA_LIM  = 2'd2,
    CFG_DIST_MAX = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR,
    ST_RSTART,
    ST_SCAN,
    ST_READ,
    ST_SQ1,
    ST_SQ2,
    ST_CMP,
    ST_RDONE,
    ST_FLUSH
  } state_e;

  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned NW = $clog2(RESULT_LIMIT + 1);

  localparam logic signed [15:0] PI_FX     = 16'sd12868;
  localparam logic signed [15:0] TWO_PI_FX = 16'sd25736;

  // Stored object position: phi in the upper half, eta in the lower.
  typedef struct packed {
    logic signed [14:0] phi;
    logic signed [14:0] eta;
  } pos_t;

endpackage

// ===== rtl/greedy_delta_r_pair_matcher_core.sv =====
// Greedy delta-R pair matcher: objects load one per cycle while the matcher is
// idle (reco or reference, cut applied on arrival, MAX_OBJECTS per side, extras
// dropped and flagged). An end-of-event item starts matching and holds the input
// off until the last result of the event has entered the output register. Each
// matching round scans every (reco, reference) pair in index order through one
// shared squarer: a pair where both objects pass and are unused steps through
// select, read, eta square, phi square, add and compare; a skipped object or
// pair and the end of each passing reco row are handled in the scan state alone,
// and each round adds restart, end of scan and round done, after the threshold
// square at the start of the event. The output register waits on m_axis only
// when a result is still pending there. Up to 16 pairs are emitted per event,
// in the order chosen, the last one marked by tlast; an event with no pair gives
// one result with pair_valid low.
module greedy_delta_r_pair_matcher_core #(
  parameter int unsigned MAX_OBJECTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // obj_pt[15:0], obj_eta[30:16], obj_phi[45:31]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // reco_index[3:0], truth_index[7:4], distance_sq[38:8]
  output logic [1:0]  m_axis_tuser,   // pair_valid[0], overflow[1]
  output logic        m_axis_tlast
);

  localparam int unsigned IW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int unsigned CW = $clog2(MAX_OBJECTS + 1);

  gdrpm_pkg::state_e state_q, state_d;

  // configuration
  logic [15:0] reco_pt_floor_q, truth_pt_floor_q;
  logic [13:0] eta_limit_q, dist_max_q;

  // event bookkeeping
  logic [CW-1:0]          reco_cnt_q, truth_cnt_q;
  logic                   dropped_q;
  logic [MAX_OBJECTS-1:0] reco_pass_q, truth_pass_q;
  logic [MAX_OBJECTS-1:0] reco_used_q, truth_used_q;

  // scan
  logic [CW-1:0]           r_q, t_q;
  logic [29:0]             thr_q;
  logic signed [15:0]      de_q, dp_q;
  logic [29:0]             acc_q;
  logic                    found_q;
  logic [IW-1:0]           best_r_q, best_t_q;
  logic [30:0]             best_d_q;
  logic                    have_pend_q;
  logic [IW-1:0]           pend_r_q, pend_t_q;
  logic [30:0]             pend_d_q;
  logic [gdrpm_pkg::NW-1:0] n_q;

  // output register
  logic        out_valid_q;
  logic [3:0]  out_r_q, out_t_q;
  logic [30:0] out_d_q;
  logic        out_pv_q, out_ov_q, out_last_q;

  // input unpack
  gdrpm_pkg::req_e    req;
  logic [15:0]        in_pt;
  logic signed [14:0] in_eta, in_phi;
  logic [14:0]        in_aeta;
  logic               in_acc, in_pass;
  logic               reco_we, truth_we;
  gdrpm_pkg::pos_t    in_pos, reco_pos, truth_pos;

  logic [IW-1:0]      ri, ti;
  logic               reco_ok, truth_ok;
  logic signed [15:0] op, de_w, dp_raw, dp_w;
  logic [29:0]        sq;
  logic [30:0]        pair_d;
  logic               emit_need, can_emit, go, emit;

  assign req    = gdrpm_pkg::req_e'(s_axis_tuser);
  assign in_pt  = s_axis_tdata[15:0];
  assign in_eta = s_axis_tdata[30:16];
  assign in_phi = s_axis_tdata[45:31];
  assign in_aeta = in_eta[14] ? 15'(-in_eta) : 15'(in_eta);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign in_pos = '{phi: in_phi, eta: in_eta};

  assign ri = r_q[IW-1:0];
  assign ti = t_q[IW-1:0];
  assign reco_ok  = reco_pass_q[ri] && !reco_used_q[ri];
  assign truth_ok = truth_pass_q[ti] && !truth_used_q[ti];
  assign pair_d = 31'(acc_q) + 31'(sq);

  gdrpm_store #(.DEPTH(MAX_OBJECTS), .AW(IW)) u_reco_store (
    .clk_i   (clk_i),
    .we_i    (reco_we),
    .waddr_i (reco_cnt_q[IW-1:0]),
    .wdata_i (in_pos),
    .raddr_i (ri),
    .rdata_o (reco_pos)
  );

  gdrpm_store #(.DEPTH(MAX_OBJECTS), .AW(IW)) u_truth_store (
    .clk_i   (clk_i),
    .we_i    (truth_we),
    .waddr_i (truth_cnt_q[IW-1:0]),
    .wdata_i (in_pos),
    .raddr_i (ti),
    .rdata_o (truth_pos)
  );

  gdrpm_sq u_sq (
    .clk_i (clk_i),
    .op_i  (op),
    .sq_o  (sq)
  );

  // Differences of the pair just read; phi wraps by one turn at most.
  always_comb begin
    de_w   = 16'(reco_pos.eta) - 16'(truth_pos.eta);
    dp_raw = 16'(reco_pos.phi) - 16'(truth_pos.phi);
    if (dp_raw > gdrpm_pkg::PI_FX) begin
      dp_w = dp_raw - gdrpm_pkg::TWO_PI_FX;
    end else if (dp_raw < -gdrpm_pkg::PI_FX) begin
      dp_w = dp_raw + gdrpm_pkg::TWO_PI_FX;
    end else begin
      dp_w = dp_raw;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state_q == gdrpm_pkg::ST_IDLE);
    in_pass  = (in_pt >= ((req == gdrpm_pkg::REQ_RECO) ? reco_pt_floor_q : truth_pt_floor_q))
               && (in_aeta <= 15'(eta_limit_q));
    reco_we  = in_acc && (req == gdrpm_pkg::REQ_RECO) && (reco_cnt_q < CW'(MAX_OBJECTS));
    truth_we = in_acc && (req == gdrpm_pkg::REQ_TRUTH) && (truth_cnt_q < CW'(MAX_OBJECTS));
    unique case (state_q)
      gdrpm_pkg::ST_SQ1: op = de_q;
      gdrpm_pkg::ST_SQ2: op = dp_q;
      default:           op = 16'(dist_max_q);
    endcase
    emit_need = have_pend_q || !found_q;
    can_emit  = !out_valid_q || m_axis_tready;
    go        = !emit_need || can_emit;
    emit      = ((state_q == gdrpm_pkg::ST_RDONE) && go && emit_need)
                || ((state_q == gdrpm_pkg::ST_FLUSH) && can_emit);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gdrpm_pkg::ST_IDLE: begin
        if (in_acc && req == gdrpm_pkg::REQ_EOE) state_d = gdrpm_pkg::ST_THR;
      end
      gdrpm_pkg::ST_THR:    state_d = gdrpm_pkg::ST_RSTART;
      gdrpm_pkg::ST_RSTART: state_d = gdrpm_pkg::ST_SCAN;
      gdrpm_pkg::ST_SCAN: begin
        if (r_q >= reco_cnt_q) begin
          state_d = gdrpm_pkg::ST_RDONE;
        end else if (reco_ok && t_q < truth_cnt_q && truth_ok) begin
          state_d = gdrpm_pkg::ST_READ;
        end
      end
      gdrpm_pkg::ST_READ: state_d = gdrpm_pkg::ST_SQ1;
      gdrpm_pkg::ST_SQ1:  state_d = gdrpm_pkg::ST_SQ2;
      gdrpm_pkg::ST_SQ2:  state_d = gdrpm_pkg::ST_CMP;
      gdrpm_pkg::ST_CMP:  state_d = gdrpm_pkg::ST_SCAN;
      gdrpm_pkg::ST_RDONE: begin
        if (go) begin
          if (!found_q) begin
            state_d = gdrpm_pkg::ST_IDLE;
          end else if (n_q + 1'b1 == gdrpm_pkg::NW'(gdrpm_pkg::RESULT_LIMIT)) begin
            state_d = gdrpm_pkg::ST_FLUSH;
          end else begin
            state_d = gdrpm_pkg::ST_RSTART;
          end
        end
      end
      gdrpm_pkg::ST_FLUSH: begin
        if (can_emit) state_d = gdrpm_pkg::ST_IDLE;
      end
      default: state_d = gdrpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdrpm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reco_pt_floor_q  <= 16'd160;
      truth_pt_floor_q <= 16'd160;
      eta_limit_q      <= 14'd4505;
      dist_max_q       <= 14'd1229;
    end else if (cfg_we_i) begin
      unique case (gdrpm_pkg::cfg_idx_e'(cfg_idx_i))
        gdrpm_pkg::CFG_RECO_PT:  reco_pt_floor_q  <= cfg_data_i;
        gdrpm_pkg::CFG_TRUTH_PT: truth_pt_floor_q <= cfg_data_i;
        gdrpm_pkg::CFG_ETA_LIM:  eta_limit_q      <= cfg_data_i[13:0];
        gdrpm_pkg::CFG_DIST_MAX: dist_max_q       <= cfg_data_i[13:0];
        default: ;
      endcase
    end
  end

  // Event control state: counts, flags, scan position, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reco_cnt_q   <= '0;
      truth_cnt_q  <= '0;
      dropped_q    <= 1'b0;
      reco_used_q  <= '0;
      truth_used_q <= '0;
      r_q          <= '0;
      t_q          <= '0;
      found_q      <= 1'b0;
      have_pend_q  <= 1'b0;
      n_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      // load a new result, or drop the one taken downstream
      if (emit) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      unique case (state_q)
        gdrpm_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (req == gdrpm_pkg::REQ_RECO) begin
              if (reco_we) reco_cnt_q <= reco_cnt_q + 1'b1;
              else         dropped_q  <= 1'b1;
            end else if (req == gdrpm_pkg::REQ_TRUTH) begin
              if (truth_we) truth_cnt_q <= truth_cnt_q + 1'b1;
              else          dropped_q   <= 1'b1;
            end else if (req == gdrpm_pkg::REQ_EOE) begin
              n_q         <= '0;
              have_pend_q <= 1'b0;
            end
          end
        end
        gdrpm_pkg::ST_RSTART: begin
          r_q     <= '0;
          t_q     <= '0;
          found_q <= 1'b0;
        end
        gdrpm_pkg::ST_SCAN: begin
          if (r_q < reco_cnt_q) begin
            if (!reco_ok || t_q >= truth_cnt_q) begin
              r_q <= r_q + 1'b1;
              t_q <= '0;
            end else if (!truth_ok) begin
              t_q <= t_q + 1'b1;
            end
          end
        end
        gdrpm_pkg::ST_CMP: begin
          if (pair_d < 31'(thr_q) && (!found_q || pair_d < best_d_q)) found_q <= 1'b1;
          t_q <= t_q + 1'b1;
        end
        gdrpm_pkg::ST_RDONE: begin
          if (go) begin
            if (found_q) begin
              have_pend_q <= 1'b1;
              reco_used_q[best_r_q]  <= 1'b1;
              truth_used_q[best_t_q] <= 1'b1;
              n_q <= n_q + 1'b1;
            end else begin
              // close the event
              reco_cnt_q   <= '0;
              truth_cnt_q  <= '0;
              dropped_q    <= 1'b0;
              reco_used_q  <= '0;
              truth_used_q <= '0;
              have_pend_q  <= 1'b0;
            end
          end
        end
        gdrpm_pkg::ST_FLUSH: begin
          if (can_emit) begin
            reco_cnt_q   <= '0;
            truth_cnt_q  <= '0;
            dropped_q    <= 1'b0;
            reco_used_q  <= '0;
            truth_used_q <= '0;
            have_pend_q  <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (reco_we)  reco_pass_q[reco_cnt_q[IW-1:0]]  <= in_pass;
    if (truth_we) truth_pass_q[truth_cnt_q[IW-1:0]] <= in_pass;
    unique case (state_q)
      gdrpm_pkg::ST_THR: thr_q <= sq;
      gdrpm_pkg::ST_READ: begin
        de_q <= de_w;
        dp_q <= dp_w;
      end
      gdrpm_pkg::ST_SQ2: acc_q <= sq;
      gdrpm_pkg::ST_CMP: begin
        if (pair_d < 31'(thr_q) && (!found_q || pair_d < best_d_q)) begin
          best_r_q <= ri;
          best_t_q <= ti;
          best_d_q <= pair_d;
        end
      end
      gdrpm_pkg::ST_RDONE: begin
        if (go) begin
          if (emit_need) begin
            out_r_q    <= have_pend_q ? 4'(pend_r_q) : 4'd0;
            out_t_q    <= have_pend_q ? 4'(pend_t_q) : 4'd0;
            out_d_q    <= have_pend_q ? pend_d_q : 31'd0;
            out_pv_q   <= have_pend_q;
            out_ov_q   <= dropped_q;
            out_last_q <= !found_q;
          end
          if (found_q) begin
            pend_r_q <= best_r_q;
            pend_t_q <= best_t_q;
            pend_d_q <= best_d_q;
          end
        end
      end
      gdrpm_pkg::ST_FLUSH: begin
        if (can_emit) begin
          out_r_q    <= 4'(pend_r_q);
          out_t_q    <= 4'(pend_t_q);
          out_d_q    <= pend_d_q;
          out_pv_q   <= 1'b1;
          out_ov_q   <= dropped_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_d_q, out_t_q, out_r_q};
  assign m_axis_tuser  = {out_ov_q, out_pv_q};
  assign m_axis_tlast  = out_last_q;

  a_best_below_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && state_q == gdrpm_pkg::ST_RDONE) |-> (best_d_q < 31'(thr_q)))
    else $error("chosen pair not below threshold");

  a_nopair_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_pv_q) |-> out_last_q)
    else $error("no-pair result without last");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (reco_cnt_q <= CW'(MAX_OBJECTS)) && (truth_cnt_q <= CW'(MAX_OBJECTS)))
    else $error("object count beyond capacity");

  a_result_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= gdrpm_pkg::NW'(gdrpm_pkg::RESULT_LIMIT))
    else $error("too many results in one event");

endmodule

// ===== rtl/gdrpm_store.sv =====
// Object position memory for one side, one write and one registered read port.
module gdrpm_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  gdrpm_pkg::pos_t  wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output gdrpm_pkg::pos_t  rdata_o
);

  gdrpm_pkg::pos_t mem [DEPTH];
  gdrpm_pkg::pos_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gdrpm_sq.sv =====
// Shared registered squarer for eta and phi differences and the threshold.
module gdrpm_sq (
  input  logic               clk_i,
  input  logic signed [15:0] op_i,
  output logic [29:0]        sq_o
);

  logic [14:0] mag;
  logic [29:0] sq_q;

  assign mag = op_i[15] ? 15'(-op_i) : 15'(op_i);

  always_ff @(posedge clk_i) begin
    sq_q <= 30'(mag) * 30'(mag);
  end

  assign sq_o = sq_q;

endmodule
